@@ sv/cdq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes of the circular deque
// Request and result beats, operation and status codes, controller commands.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam logic [1:0] FN_PUSH_FRONT = 2'd0;
	localparam logic [1:0] FN_PUSH_BACK  = 2'd1;
	localparam logic [1:0] FN_POP_FRONT  = 2'd2;
	localparam logic [1:0] FN_POP_BACK   = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int OCC_W = 5;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [OCC_W-1:0]   occupancy;
		logic               is_empty;
		logic               is_full;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

@@ sv/circular_deque.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of 32-bit words in a circular store
// Usage:
//   Request channel: drive req (func, value) with start high; the beat is
//   taken at a rising edge where start is high and busy is low. func selects
//   push front, push back, pop front or pop back.
//   Result channel: done pulses for one cycle with rsp valid (read_value,
//   status, occupancy, is_empty, is_full). The receiver cannot stall; a
//   result not captured in that cycle is gone.
//   Sequence: the accepting edge moves the controller to EXEC, which
//   updates pointers, count and one store entry; done and the result
//   follow in the RESP state, since the store read is registered.
//   Overlap: no request is taken while one is in EXEC; start may be held
//   during the result cycle to issue the next request back to back.
//   Refused requests (push when full, pop when empty) leave state unchanged
//   and return read_value zero.
//   Reset: arst_n clears pointers and count to an empty deque; the store
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module circular_deque #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cdq_pkg::req_t req,
	output logic          done,
	output cdq_pkg::rsp_t rsp
);

	cdq_pkg::ctrl_cmd_t cmd;

	cdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	cdq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted beat did not enter execute");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != cdq_pkg::ST_DONE) |-> (rsp.read_value == '0))
		else $error("refused request returned nonzero data");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.is_full && rsp.status == cdq_pkg::ST_EMPTY))
		else $error("empty refusal reported with full flag");

endmodule

@@ sv/cdq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl: request sequencer
// Accepts a request, runs it in the EXEC state, then strobes the result in RESP.
// ----------------------------------------------------------------------------
module cdq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output cdq_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		EXEC,
		RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= EXEC;
						busy_q  <= 1'b1;
					end
				end
				EXEC: begin
					state_q <= RESP;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				RESP: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= EXEC;
						busy_q  <= 1'b1;
					end else begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign cmd.load = start && !busy_q;
	assign cmd.exec = (state_q == EXEC);

endmodule

@@ sv/cdq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_datapath: slot store, head and tail pointers, entry count
// Executes one request per exec command and holds the result fields.
// ----------------------------------------------------------------------------
module cdq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cdq_pkg::ctrl_cmd_t cmd,
	input  cdq_pkg::req_t      req,
	output cdq_pkg::rsp_t      rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [31:0]       mem [DEPTH];
	logic [31:0]       rd_data_q;
	logic [1:0]        func_q;
	logic [31:0]       value_q;
	logic [IW-1:0]     head_q, tail_q;
	logic [CW-1:0]     count_q;
	logic [1:0]        status_q;
	logic              pop_ok_q;

	logic              full, empty;
	logic [IW-1:0]     head_up, head_dn, tail_up, tail_dn;
	logic [IW-1:0]     head_nx, tail_nx, wr_addr, rd_addr;
	logic [CW-1:0]     count_nx;
	logic [1:0]        status_nx;
	logic              wr_en, rd_en;
	logic [CW+4:0]     occ_ext;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign head_up = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign head_dn = (head_q == '0) ? LAST : head_q - 1'b1;
	assign tail_up = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign tail_dn = (tail_q == '0) ? LAST : tail_q - 1'b1;

	always_comb begin
		head_nx   = head_q;
		tail_nx   = tail_q;
		count_nx  = count_q;
		status_nx = cdq_pkg::ST_DONE;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		wr_addr   = tail_q;
		rd_addr   = head_q;
		case (func_q)
			cdq_pkg::FN_PUSH_FRONT: begin
				if (full) begin
					status_nx = cdq_pkg::ST_FULL;
				end else begin
					wr_en    = 1'b1;
					wr_addr  = head_dn;
					head_nx  = head_dn;
					count_nx = count_q + 1'b1;
				end
			end
			cdq_pkg::FN_PUSH_BACK: begin
				if (full) begin
					status_nx = cdq_pkg::ST_FULL;
				end else begin
					wr_en    = 1'b1;
					wr_addr  = tail_q;
					tail_nx  = tail_up;
					count_nx = count_q + 1'b1;
				end
			end
			cdq_pkg::FN_POP_FRONT: begin
				if (empty) begin
					status_nx = cdq_pkg::ST_EMPTY;
				end else begin
					rd_en    = 1'b1;
					rd_addr  = head_q;
					head_nx  = head_up;
					count_nx = count_q - 1'b1;
				end
			end
			default: begin
				if (empty) begin
					status_nx = cdq_pkg::ST_EMPTY;
				end else begin
					rd_en    = 1'b1;
					rd_addr  = tail_dn;
					tail_nx  = tail_dn;
					count_nx = count_q - 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= req.func;
			value_q <= req.value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= value_q;
		end
		if (cmd.exec && rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			status_q <= cdq_pkg::ST_DONE;
			pop_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			head_q   <= head_nx;
			tail_q   <= tail_nx;
			count_q  <= count_nx;
			status_q <= status_nx;
			pop_ok_q <= rd_en;
		end
	end

	assign occ_ext = {5'b0, count_q};

	assign rsp.read_value = pop_ok_q ? rd_data_q : '0;
	assign rsp.status     = status_q;
	assign rsp.occupancy  = occ_ext[cdq_pkg::OCC_W-1:0];
	assign rsp.is_empty   = empty;
	assign rsp.is_full    = full;

endmodule

@@ tb/circular_deque_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb: self-checking bench for the circular deque
// Drives push/pop requests with random gaps through the start/busy handshake.
// A scoreboard keeps its own deque model, predicts each result beat and
// compares it field by field against the done-strobed response. A directed
// pass covers empty and full refusals, index wrap and extreme words. Random
// phases bias toward filling or draining, or mix the two evenly.
// ----------------------------------------------------------------------------
module circular_deque_tb;

	localparam int DEPTH          = 16;
	localparam int RANDOM_ITEMS   = 1350;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;

	class deque_scoreboard;
		logic signed [31:0] slots [DEPTH];
		int                 head;
		int                 tail;
		int                 count;
		cdq_pkg::rsp_t      pending [$];

		function new();
			head  = 0;
			tail  = 0;
			count = 0;
		endfunction

		function void note_request(cdq_pkg::req_t r);
			cdq_pkg::rsp_t e;
			e        = '0;
			e.status = cdq_pkg::ST_DONE;
			case (r.func)
				cdq_pkg::FN_PUSH_FRONT: begin
					if (count == DEPTH) begin
						e.status = cdq_pkg::ST_FULL;
					end else begin
						head        = (head + DEPTH - 1) % DEPTH;
						slots[head] = r.value;
						count++;
					end
				end
				cdq_pkg::FN_PUSH_BACK: begin
					if (count == DEPTH) begin
						e.status = cdq_pkg::ST_FULL;
					end else begin
						slots[tail] = r.value;
						tail        = (tail + 1) % DEPTH;
						count++;
					end
				end
				cdq_pkg::FN_POP_FRONT: begin
					if (count == 0) begin
						e.status = cdq_pkg::ST_EMPTY;
					end else begin
						e.read_value = slots[head];
						head         = (head + 1) % DEPTH;
						count--;
					end
				end
				default: begin
					if (count == 0) begin
						e.status = cdq_pkg::ST_EMPTY;
					end else begin
						tail         = (tail + DEPTH - 1) % DEPTH;
						e.read_value = slots[tail];
						count--;
					end
				end
			endcase
			e.occupancy = count[cdq_pkg::OCC_W-1:0];
			e.is_empty  = (count == 0);
			e.is_full   = (count == DEPTH);
			pending.push_back(e);
		endfunction

		function string check_result(cdq_pkg::rsp_t got);
			cdq_pkg::rsp_t e;
			string         why;
			if (pending.size() == 0)
				return " result beat with no request outstanding";
			e   = pending.pop_front();
			why = "";
			if (got.read_value !== e.read_value)
				why = {why, $sformatf(" read_value %0d exp %0d", got.read_value, e.read_value)};
			if (got.status !== e.status)
				why = {why, $sformatf(" status %0d exp %0d", got.status, e.status)};
			if (got.occupancy !== e.occupancy)
				why = {why, $sformatf(" occupancy %0d exp %0d", got.occupancy, e.occupancy)};
			if (got.is_empty !== e.is_empty)
				why = {why, $sformatf(" is_empty %0b exp %0b", got.is_empty, e.is_empty)};
			if (got.is_full !== e.is_full)
				why = {why, $sformatf(" is_full %0b exp %0b", got.is_full, e.is_full)};
			return why;
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          start;
	logic          busy;
	cdq_pkg::req_t req;
	logic          done;
	cdq_pkg::rsp_t rsp;

	deque_scoreboard sb;
	int              mismatches  = 0;
	int              idle_cycles = 0;

	always #5 clk = ~clk;

	circular_deque #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t:%s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		string why;
		if (arst_n) begin
			if (done) begin
				why = sb.check_result(rsp);
				if (why != "")
					report_mismatch(why);
			end
			if (start && !busy)
				sb.note_request(req);
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// hold start high across back-to-back beats; drop it only for a gap
	task automatic send_request(input logic [1:0] f, input logic signed [31:0] v,
		input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		req.func  <= f;
		req.value <= v;
		do @(posedge clk); while (busy);
	endtask

	function automatic int pick_gap(input bit idling);
		int r;
		if (!idling)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sh0000_0000;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int          sent;
		int          phase_len;
		int          push_pct;
		bit          idling;
		logic [1:0]  f;

		sb     = new();
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// refusals on empty, wrap at both ends, extreme words
		send_request(cdq_pkg::FN_POP_FRONT, 32'sh1234_5678, 0);
		send_request(cdq_pkg::FN_POP_BACK, -32'sd1, 0);
		send_request(cdq_pkg::FN_PUSH_FRONT, 32'sh7FFF_FFFF, 0);
		send_request(cdq_pkg::FN_PUSH_BACK, 32'sh8000_0000, 0);
		send_request(cdq_pkg::FN_POP_BACK, 32'sh0, 0);
		send_request(cdq_pkg::FN_POP_FRONT, 32'sh0, 0);
		for (int i = 0; i < DEPTH / 2; i++) begin
			send_request(cdq_pkg::FN_PUSH_FRONT,
				(i % 2) ? 32'shAAAA_AAAA : 32'sh5555_5555, 0);
			send_request(cdq_pkg::FN_PUSH_BACK, (i % 2) ? -32'sd1 : 32'sh0, 0);
		end
		send_request(cdq_pkg::FN_PUSH_FRONT, 32'sh0F0F_0F0F, 0);
		send_request(cdq_pkg::FN_PUSH_BACK, 32'shF0F0_F0F0, 0);
		send_request(cdq_pkg::FN_POP_FRONT, 32'sh0, 0);
		send_request(cdq_pkg::FN_POP_BACK, 32'sh0, 0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0:       push_pct = 10;
				1:       push_pct = 50;
				2:       push_pct = 90;
				default: push_pct = 97;
			endcase
			idling    = ($urandom_range(0, 3) != 0);
			phase_len = $urandom_range(20, 60);
			for (int k = 0; k < phase_len; k++) begin
				if ($urandom_range(0, 99) < push_pct)
					f = $urandom_range(0, 1) ? cdq_pkg::FN_PUSH_BACK : cdq_pkg::FN_PUSH_FRONT;
				else
					f = $urandom_range(0, 1) ? cdq_pkg::FN_POP_BACK : cdq_pkg::FN_POP_FRONT;
				send_request(f, pick_word(), pick_gap(idling));
				sent++;
			end
		end
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
sv/cdq_pkg.sv
sv/cdq_ctrl.sv
sv/cdq_datapath.sv
sv/circular_deque.sv
tb/circular_deque_tb.sv
